[hw/rtl/sdx_pkg.sv]
// Shared types, constants and the character classifier of the Soundex encoder.
package sdx_pkg;

  localparam int unsigned MidDepth = 2;
  localparam int unsigned MidPtrW  = (MidDepth > 1) ? $clog2(MidDepth) : 1;
  localparam int unsigned MidCntW  = $clog2(MidDepth + 1);

  localparam int unsigned OutDepth = 2;
  localparam int unsigned OutPtrW  = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam int unsigned NumDigits = 3;

  localparam logic [2:0] CodeNone = 3'd0;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } sdx_in_t;

  typedef struct packed {
    logic [7:0] first_letter;
    logic [2:0] digit_one;
    logic [2:0] digit_two;
    logic [2:0] digit_three;
  } sdx_out_t;

  typedef struct packed {
    logic [7:0] upper;
    logic [2:0] code;
    logic       is_h_or_w;
    logic       last;
  } sdx_cls_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [2:0] code_of(input logic [7:0] c);
    logic [2:0] r;
    r = CodeNone;
    unique case (to_lower(c)) inside
      "b", "f", "p", "v":                     r = 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": r = 3'd2;
      "d", "t":                               r = 3'd3;
      "l":                                    r = 3'd4;
      "m", "n":                               r = 3'd5;
      "r":                                    r = 3'd6;
      default:                                r = CodeNone;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/sdx_front.sv]
// Front end: classifies each incoming character into its code and flags.
module sdx_front (
  input  sdx_pkg::sdx_in_t  in_data_i,
  output sdx_pkg::sdx_cls_t cls_o
);
  import sdx_pkg::*;

  logic [7:0] lower;

  assign lower            = to_lower(in_data_i.char_in);
  assign cls_o.upper      = to_upper(in_data_i.char_in);
  assign cls_o.code       = code_of(in_data_i.char_in);
  assign cls_o.is_h_or_w  = (lower == "h") || (lower == "w");
  assign cls_o.last       = in_data_i.last_char;

endmodule

[hw/rtl/sdx_queue.sv]
// Short queue of classified characters between the front and back ends.
module sdx_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  sdx_pkg::sdx_cls_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              valid_o,
  output sdx_pkg::sdx_cls_t rd_data_o
);
  import sdx_pkg::*;

  sdx_cls_t           mem_q [MidDepth];
  logic [MidPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [MidPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [MidCntW-1:0] cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign full_o    = (cnt_q == MidCntW'(MidDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == MidPtrW'(MidDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == MidPtrW'(MidDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[hw/rtl/sdx_back.sv]
// Back end: applies the Soundex rules per character and buffers finished codes.
module sdx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sdx_pkg::sdx_cls_t cls_i,
  output logic              take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output sdx_pkg::sdx_out_t out_data_o
);
  import sdx_pkg::*;

  logic [2:0] prev_code_q, prev_code_d;
  logic [2:0] prev_prev_code_q, prev_prev_code_d;
  logic       prev_hw_q, prev_hw_d;
  logic [1:0] pos_q, pos_d;
  logic [1:0] filled_q, filled_d;
  logic [7:0] first_q, first_d;
  logic [2:0] dig0_q, dig0_d, dig1_q, dig1_d, dig2_q, dig2_d;
  logic       skip;

  sdx_out_t           buf_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  logic               buf_full, res_wr, do_pop;
  sdx_out_t           res;

  assign buf_full   = (cnt_q == OutCntW'(OutDepth));
  assign empty_o    = (cnt_q == '0);
  assign out_data_o = buf_q[rd_ptr_q];
  assign take_o     = valid_i && !(cls_i.last && buf_full);
  assign res_wr     = take_o && cls_i.last;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    prev_code_d      = prev_code_q;
    prev_prev_code_d = prev_prev_code_q;
    prev_hw_d        = prev_hw_q;
    pos_d            = pos_q;
    filled_d         = filled_q;
    first_d          = first_q;
    dig0_d           = dig0_q;
    dig1_d           = dig1_q;
    dig2_d           = dig2_q;
    skip             = (pos_q == 2'd2) && (cls_i.code == prev_prev_code_q) && prev_hw_q;
    if (take_o) begin
      if (pos_q == 2'd0) begin
        first_d          = cls_i.upper;
        dig0_d           = CodeNone;
        dig1_d           = CodeNone;
        dig2_d           = CodeNone;
        filled_d         = '0;
        prev_prev_code_d = CodeNone;
        pos_d            = 2'd1;
      end else begin
        if (filled_q < 2'(NumDigits) && cls_i.code != CodeNone &&
            cls_i.code != prev_code_q && !skip) begin
          case (filled_q)
            2'd0:    dig0_d = cls_i.code;
            2'd1:    dig1_d = cls_i.code;
            default: dig2_d = cls_i.code;
          endcase
          filled_d = filled_q + 1'b1;
        end
        prev_prev_code_d = prev_code_q;
        if (pos_q != 2'd2) begin
          pos_d = pos_q + 1'b1;
        end
      end
      prev_code_d = cls_i.code;
      prev_hw_d   = cls_i.is_h_or_w;
      if (cls_i.last) begin
        pos_d = 2'd0;
      end
    end
  end

  assign res.first_letter = first_d;
  assign res.digit_one    = dig0_d;
  assign res.digit_two    = dig1_d;
  assign res.digit_three  = dig2_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (res_wr) begin
      wr_ptr_d = (wr_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (res_wr && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !res_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_code_q      <= CodeNone;
      prev_prev_code_q <= CodeNone;
      prev_hw_q        <= 1'b0;
      pos_q            <= '0;
      filled_q         <= '0;
      first_q          <= '0;
      dig0_q           <= CodeNone;
      dig1_q           <= CodeNone;
      dig2_q           <= CodeNone;
      wr_ptr_q         <= '0;
      rd_ptr_q         <= '0;
      cnt_q            <= '0;
    end else begin
      prev_code_q      <= prev_code_d;
      prev_prev_code_q <= prev_prev_code_d;
      prev_hw_q        <= prev_hw_d;
      pos_q            <= pos_d;
      filled_q         <= filled_d;
      first_q          <= first_d;
      dig0_q           <= dig0_d;
      dig1_q           <= dig1_d;
      dig2_q           <= dig2_d;
      wr_ptr_q         <= wr_ptr_d;
      rd_ptr_q         <= rd_ptr_d;
      cnt_q            <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

endmodule

[hw/rtl/soundex_encoder.sv]
// Top level of the streaming American Soundex encoder.
//
// Characters of a word enter on the input queue port: in_data_i is taken at
// a rising edge where push is high and full is low. The item flagged
// last_char closes the word and produces one Soundex code; other items
// produce nothing. Codes leave on the result queue port: while empty is low
// out_data_o holds the oldest code, and it is removed at an edge where pop is
// high. The front end classifies a character as it is accepted and writes it
// to a two-entry queue; the back end applies the adjacency rules to one
// character per cycle and writes finished codes into a two-entry buffer.
// Throughput is one character per cycle while the receiver keeps up. A code
// is written into the result buffer before it appears on out_data_o. When the
// receiver stalls, the result buffer fills, the back end holds the closing
// character, the middle queue fills and full rises; nothing is dropped. Reset
// empties both queues and returns the encoder to the start of a word.
module soundex_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sdx_pkg::sdx_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output sdx_pkg::sdx_out_t out_data_o
);
  import sdx_pkg::*;

  sdx_cls_t cls_in, cls_head;
  logic     mid_valid, mid_take;

  sdx_front u_front (
    .in_data_i (in_data_i),
    .cls_o     (cls_in)
  );

  sdx_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (cls_in),
    .full_o    (full),
    .rd_i      (mid_take),
    .valid_o   (mid_valid),
    .rd_data_o (cls_head)
  );

  sdx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mid_valid),
    .cls_i      (cls_head),
    .take_o     (mid_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

endmodule

[dv/tb_soundex_encoder.sv]
// Self-checking testbench for the streaming Soundex encoder with random stalls on both sides.
module tb_soundex_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sdx_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomChars = 700;
  localparam int unsigned PhaseChars  = 140;
  localparam int unsigned SettleWait  = 8;

  typedef struct {
    sdx_in_t     data;
    int unsigned gap;
    bit          drain;
    bit          calm;
  } pend_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     push      = 1'b0;
  logic     pop       = 1'b0;
  sdx_in_t  in_data_i = '0;
  logic     full;
  logic     empty;
  sdx_out_t out_data_o;

  pend_t    char_q[$];
  sdx_out_t code_q[$];

  logic       in_took = 1'b0;
  int unsigned tx_gap   = 0;
  int unsigned rx_stall = 0;
  bit          rx_calm  = 1'b0;

  int unsigned n_chars  = 0;
  int unsigned n_words  = 0;
  int unsigned n_codes  = 0;
  int unsigned n_drains = 0;
  int unsigned errors   = 0;
  int unsigned idle_cycles = 0;

  logic [1:0] word_pos  = 2'd0;
  logic [2:0] last_code = 3'd0;
  logic [2:0] older_code = 3'd0;
  logic       last_hw   = 1'b0;
  int unsigned n_digits = 0;
  logic [7:0] lead_char = 8'd0;
  logic [2:0] digit_reg [3];

  soundex_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [2:0] letter_code(input logic [7:0] lc);
    case (lc)
      "b", "f", "p", "v":                     return 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
      "d", "t":                               return 3'd3;
      "l":                                    return 3'd4;
      "m", "n":                               return 3'd5;
      "r":                                    return 3'd6;
      default:                                return 3'd0;
    endcase
  endfunction

  task automatic predict_char(input sdx_in_t item);
    logic [7:0] c;
    logic [7:0] lc;
    logic [2:0] cd;
    logic       hw;
    sdx_out_t   res;
    c  = item.char_in;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    cd = letter_code(lc);
    hw = (lc == "h" || lc == "w");
    if (word_pos == 2'd0) begin
      lead_char    = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
      digit_reg[0] = 3'd0;
      digit_reg[1] = 3'd0;
      digit_reg[2] = 3'd0;
      n_digits     = 0;
      older_code   = 3'd0;
      last_code    = cd;
      last_hw      = hw;
      word_pos     = 2'd1;
    end else begin
      if (n_digits < 3 && cd != 3'd0 && cd != last_code &&
          !(word_pos >= 2'd2 && cd == older_code && last_hw)) begin
        digit_reg[n_digits] = cd;
        n_digits++;
      end
      older_code = last_code;
      last_code  = cd;
      last_hw    = hw;
      if (word_pos < 2'd2) word_pos++;
    end
    if (item.last_char) begin
      res.first_letter = lead_char;
      res.digit_one    = digit_reg[0];
      res.digit_two    = digit_reg[1];
      res.digit_three  = digit_reg[2];
      code_q.push_back(res);
      word_pos = 2'd0;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    sdx_out_t want;
    if (rst_ni) begin
      in_took <= push && !full;
      if (pop && !empty) begin
        n_codes++;
        if (code_q.size() == 0) begin
          $display("%0t: unexpected code, expected none, actual %h", $time, out_data_o);
          errors++;
        end else begin
          want = code_q.pop_front();
          check_field("first_letter", want.first_letter, out_data_o.first_letter);
          check_field("digit_one", want.digit_one, out_data_o.digit_one);
          check_field("digit_two", want.digit_two, out_data_o.digit_two);
          check_field("digit_three", want.digit_three, out_data_o.digit_three);
        end
      end
      if (push && !full) predict_char(in_data_i);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: watchdog, no item moved for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    logic next_push;
    if (rst_ni) begin
      next_push = push;
      if (push && in_took) next_push = 1'b0;
      if (!next_push) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (char_q.size() > 0) begin
          if (char_q[0].drain) begin
            if (code_q.size() == 0) begin
              rx_calm = char_q[0].calm;
              n_drains++;
              void'(char_q.pop_front());
            end
          end else begin
            in_data_i <= char_q[0].data;
            tx_gap    = char_q[0].gap;
            void'(char_q.pop_front());
            next_push = 1'b1;
          end
        end
      end
      push <= next_push;
      if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall = pause_len();
      end
    end
  end

  task automatic add_char(input logic [7:0] c, input bit last, input bit calm);
    pend_t p;
    p.data.char_in   = c;
    p.data.last_char = last;
    p.gap   = calm ? 0 : pause_len();
    p.drain = 1'b0;
    p.calm  = 1'b0;
    char_q.push_back(p);
    n_chars++;
    if (last) n_words++;
  endtask

  task automatic add_word(input string w, input bit calm);
    for (int i = 0; i < w.len(); i++) begin
      add_char(w[i], i == w.len() - 1, calm);
    end
  endtask

  task automatic add_drain(input bit calm_next);
    pend_t p;
    p.data  = '0;
    p.gap   = 0;
    p.drain = 1'b1;
    p.calm  = calm_next;
    char_q.push_back(p);
  endtask

  task automatic add_random_word(input bit calm);
    string       hw_set;
    int unsigned len;
    int unsigned r;
    logic [7:0]  c;
    logic [7:0]  prev_c;
    hw_set = "hHwW";
    if ($urandom_range(0, 9) == 0) begin
      add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), calm);
    end else begin
      len    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 14);
      prev_c = 8'h61;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          c = prev_c;
        end else if (r < 70) begin
          c = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
        end else if (r < 82) begin
          c = hw_set[$urandom_range(0, 3)];
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        add_char(c, i == len - 1, calm);
        prev_c = c;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    bit          calm;

    // Directed words: extreme bytes, one-character words, case folding,
    // the h/w separator rule, and characters ignored after three digits.
    add_char(8'h00, 1'b1, 1'b0);
    add_word("robert", 1'b0);
    add_word("aSHcrAFt", 1'b0);
    add_char(8'hff, 1'b0, 1'b0);
    add_word("bWBl", 1'b0);
    add_word("Lloyd", 1'b0);
    add_drain(1'b0);

    phase = 0;
    while (n_chars < RandomChars + 25) begin
      calm   = (phase % 3 == 2);
      target = n_chars + PhaseChars;
      while (n_chars < target) add_random_word(calm);
      phase++;
      add_drain(phase % 3 == 2);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_q.size() != 0 || push || code_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    $display("Sent %0d characters closing %0d words; %0d codes compared.",
             n_chars, n_words, n_codes);
    $display("Run included %0d full drains and stretches with and without stalls.", n_drains);
    if (errors == 0 && code_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
